>>> hdl/ar1_pkg.sv
// Shared types and constants for the AR(1) Gaussian log-likelihood unit.
// No dependencies.
`timescale 1ns / 1ps
package ar1_pkg;
    localparam int NUM_BETAS = 4;
    localparam int FIT_W = 35;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [32:0] LN2_Q32 = 33'd2977044472;
    localparam logic [15:0] HALF_LN_2PI_Q16 = 16'd60224;
    localparam logic signed [31:0] MIN_LL_RESET = -32'sd655360;
    localparam logic [2:0] NUM_BETAS_RESET = 3'd4;

    localparam logic CFG_MIN_LL = 1'b0;
    localparam logic CFG_NUM_BETAS = 1'b1;

    typedef struct packed {
        logic signed [FIT_W-1:0] fit;
        logic signed [31:0]      rho;
        logic signed [31:0]      sigma;
        logic signed [31:0]      sample;
        logic                    valid;
        logic                    last;
    } t_row;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage

>>> hdl/ar1_gaussian_log_likelihood_sum_unit.sv
// Top level: config registers, front queue and back scoring engine.
// Depends on ar1_pkg, ar1_front, ar1_back.
// Each row passes through the 17-step root, then the 26-step divider beside the
// log2 unit (up to 30 normalize steps + 16 squares).
// The engine scores one row at a time; the queue takes rows while the engine
// works, and an unpopped total holds the engine at the next last row.
// Synchronous active-low reset clears the queue, series state and output.
`timescale 1ns / 1ps
module ar1_gaussian_log_likelihood_sum_unit #(
    parameter int QUEUE_DEPTH = ar1_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [31:0]         i_cfg_data,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  i_beta_0,
    input  logic signed [31:0]  i_beta_1,
    input  logic signed [31:0]  i_beta_2,
    input  logic signed [31:0]  i_beta_3,
    input  logic signed [31:0]  i_rho,
    input  logic signed [31:0]  i_sigma,
    input  logic signed [31:0]  i_sample,
    input  logic                i_row_valid,
    input  logic                i_last_row,
    output logic                empty,
    input  logic                pop,
    output logic signed [47:0]  o_total_log_likelihood
);
    import ar1_pkg::*;

    logic signed [31:0] r_min_ll;
    logic [2:0]         r_num_betas;
    logic signed [31:0] betas [NUM_BETAS];
    t_row               head;
    t_q_stat            stat;
    logic               q_pop;

    assign betas[0] = i_beta_0;
    assign betas[1] = i_beta_1;
    assign betas[2] = i_beta_2;
    assign betas[3] = i_beta_3;
    assign full = stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ll    <= MIN_LL_RESET;
            r_num_betas <= NUM_BETAS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MIN_LL:    r_min_ll    <= i_cfg_data;
                CFG_NUM_BETAS: r_num_betas <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    ar1_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_betas(betas),
        .i_rho(i_rho), .i_sigma(i_sigma), .i_sample(i_sample),
        .i_row_valid(i_row_valid), .i_last_row(i_last_row),
        .i_num_betas(r_num_betas), .i_pop(q_pop), .o_head(head), .o_stat(stat)
    );

    ar1_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(head), .i_stat(stat),
        .o_q_pop(q_pop), .i_min_ll(r_min_ll), .i_pop(pop), .o_empty(empty),
        .o_total(o_total_log_likelihood)
    );

    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.full && stat.empty))
        else $error("queue both full and empty");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> !stat.empty)
        else $error("accepted item missing from queue");
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");
    a_pop_only_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !stat.empty)
        else $error("engine took from empty queue");
endmodule

>>> hdl/ar1_front.sv
// Front end: sums the first i_num_betas betas (at most NUM_BETAS) into the fitted value and queues the row.
// Depends on ar1_pkg.
`timescale 1ns / 1ps
module ar1_front #(
    parameter int QUEUE_DEPTH = ar1_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic signed [31:0]   i_betas [ar1_pkg::NUM_BETAS],
    input  logic signed [31:0]   i_rho,
    input  logic signed [31:0]   i_sigma,
    input  logic signed [31:0]   i_sample,
    input  logic                 i_row_valid,
    input  logic                 i_last_row,
    input  logic [2:0]           i_num_betas,
    input  logic                 i_pop,
    output ar1_pkg::t_row        o_head,
    output ar1_pkg::t_q_stat     o_stat
);
    import ar1_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_row            r_q [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic [2:0]      nb;
    logic signed [FIT_W-1:0] fit;
    logic            wr_en, rd_en;

    always_comb begin
        nb = (i_num_betas > 3'(NUM_BETAS)) ? 3'(NUM_BETAS) : i_num_betas;
        fit = '0;
        for (int k = 0; k < NUM_BETAS; k++) begin
            if (3'(k) < nb) fit = fit + FIT_W'(i_betas[k]);
        end
    end

    assign o_stat.full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign wr_en = i_push && !o_stat.full;
    assign rd_en = i_pop && !o_stat.empty;
    assign o_head = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= '{fit: fit, rho: i_rho, sigma: i_sigma, sample: i_sample,
                           valid: i_row_valid, last: i_last_row};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (rd_en) r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (wr_en && !rd_en) r_cnt <= r_cnt + 1'b1;
            else if (rd_en && !wr_en) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

>>> hdl/ar1_back.sv
// Back end: sequential scoring engine (sqrt, divide, log2) and the running total.
// Depends on ar1_pkg.
`timescale 1ns / 1ps
module ar1_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ar1_pkg::t_row        i_head,
    input  ar1_pkg::t_q_stat     i_stat,
    output logic                 o_q_pop,
    input  logic signed [31:0]   i_min_ll,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic signed [47:0]   o_total
);
    import ar1_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_PREP = 3'd1, S_SQRT = 3'd2, S_SD = 3'd3,
                           S_DINIT = 3'd4, S_RUN = 3'd5, S_MUL = 3'd6, S_FIN = 3'd7;
    localparam logic signed [47:0] TOT_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] TOT_MIN = {1'b1, {47{1'b0}}};

    logic [2:0]              r_state;
    logic [3:0]              r_sub;
    t_row                    r_row;
    logic signed [31:0]      r_prev_sample;
    logic signed [FIT_W-1:0] r_prev_fit;
    logic                    r_first;
    logic signed [47:0]      r_total;
    logic                    r_out_valid;
    logic signed [47:0]      r_out_total;
    logic                    r_ok;
    logic signed [53:0]      r_prod;
    logic [33:0]             r_x, r_root, r_bit;
    logic [4:0]              r_cnt;
    logic [31:0]             r_sd;
    logic signed [39:0]      r_mean;
    logic [31:0]             r_rem;
    logic [25:0]             r_nbits, r_q;
    logic                    r_cap;
    logic [30:0]             r_m;
    logic [4:0]              r_ncnt, r_sqi;
    logic                    r_lsq, r_ldone;
    logic signed [21:0]      r_l2;
    logic [51:0]             r_u2;
    logic signed [55:0]      r_lnp;
    logic signed [47:0]      r_t;

    // combinational helpers
    logic signed [17:0] rho18;
    logic signed [35:0] d0, rho2;
    logic               rho_in;
    logic [47:0]        sdl;
    logic [31:0]        sd_c;
    logic [53:0]        pmag;
    logic [37:0]        rmag;
    logic signed [39:0] shift_c;
    logic signed [40:0] d_c;
    logic [40:0]        ad;
    logic [32:0]        dtmp;
    logic [61:0]        mm;
    logic [31:0]        m2;
    logic [25:0]        u;
    logic [55:0]        lmag;
    logic [23:0]        lnr;
    logic signed [24:0] ln_c;
    logic [34:0]        half;
    logic signed [37:0] score, score_cl;
    logic signed [48:0] tsum;

    always_comb begin
        rho18  = r_row.rho[17:0];
        rho_in = (r_row.rho > -32'sd65536) && (r_row.rho < 32'sd65536);
        d0     = 36'(r_prev_sample) - 36'(r_prev_fit);
        rho2   = rho18 * rho18;
        sdl    = {17'b0, r_row.sigma[30:0]} * {31'b0, r_root[16:0]};
        sd_c   = r_first ? r_row.sigma : sdl[47:16];
        pmag   = r_prod[53] ? 54'(-r_prod) : 54'(r_prod);
        rmag   = 38'((pmag + 54'd32768) >> 16);
        shift_c = r_prod[53] ? -$signed({2'b0, rmag}) : $signed({2'b0, rmag});
        d_c    = 41'(r_row.sample) - 41'(r_mean);
        ad     = d_c[40] ? 41'(-d_c) : 41'(d_c);
        dtmp   = {r_rem, r_nbits[25]};
        mm     = {31'b0, r_m} * {31'b0, r_m};
        m2     = mm[61:30];
        u      = (r_cap || r_q > 26'd33554432) ? 26'd33554432 : r_q;
        lmag   = r_lnp[55] ? 56'(-r_lnp) : 56'(r_lnp);
        lnr    = 24'((lmag + 56'd2147483648) >> 32);
        ln_c   = r_lnp[55] ? -$signed({1'b0, lnr}) : $signed({1'b0, lnr});
        half   = 35'((r_u2 + 52'd65536) >> 17);
        score  = -38'(ln_c) - 38'($signed({1'b0, HALF_LN_2PI_Q16}))
                 - $signed({3'b0, half});
        score_cl = (!r_ok || score < 38'(i_min_ll)) ? 38'(i_min_ll) : score;
        tsum   = 49'(r_total) + 49'(score_cl);
    end

    assign o_q_pop = (r_state == S_IDLE) && !i_stat.empty;
    assign o_empty = !r_out_valid;
    assign o_total = r_out_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prev_sample <= '0;
            r_prev_fit    <= '0;
            r_first       <= 1'b1;
            r_total       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_stat.empty) begin
                        r_row   <= i_head;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_ok   <= r_row.valid && (r_row.sigma > 0) && (r_first || rho_in);
                    r_prod <= rho18 * d0;
                    r_x    <= 34'h1_0000_0000 - {2'b0, rho2[31:0]};
                    r_root <= '0;
                    r_bit  <= 34'h1_0000_0000;
                    r_cnt  <= 5'd17;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_x >= r_root + r_bit) begin
                        r_x    <= r_x - (r_root + r_bit);
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 5'd1) r_state <= S_SD;
                end
                S_SD: begin
                    r_sd   <= sd_c;
                    r_mean <= r_first ? 40'(r_row.fit) : 40'(r_row.fit) + shift_c;
                    if (sd_c == '0) r_ok <= 1'b0;
                    r_state <= S_DINIT;
                end
                S_DINIT: begin
                    r_cap   <= {1'b0, ad} >= {r_sd, 10'b0};
                    r_rem   <= {1'b0, ad[40:10]};
                    r_nbits <= {ad[9:0], 16'b0};
                    r_q     <= '0;
                    r_cnt   <= 5'd26;
                    r_m     <= r_sd[30:0];
                    r_ncnt  <= '0;
                    r_lsq   <= 1'b0;
                    r_ldone <= 1'b0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    // divider, one quotient bit a cycle
                    if (r_cnt != '0) begin
                        if (dtmp >= {1'b0, r_sd}) begin
                            r_rem <= 32'(dtmp - {1'b0, r_sd});
                            r_q   <= {r_q[24:0], 1'b1};
                        end else begin
                            r_rem <= dtmp[31:0];
                            r_q   <= {r_q[24:0], 1'b0};
                        end
                        r_nbits <= r_nbits << 1;
                        r_cnt   <= r_cnt - 1'b1;
                    end
                    // log2: normalize mantissa, then one fraction bit per square
                    if (!r_lsq) begin
                        if (!r_m[30] && r_ncnt != 5'd30) begin
                            r_m    <= r_m << 1;
                            r_ncnt <= r_ncnt + 1'b1;
                        end else begin
                            r_lsq <= 1'b1;
                            r_l2  <= 22'($signed(6'sd14 - $signed({1'b0, r_ncnt}))) <<< 16;
                            r_sqi <= '0;
                        end
                    end else if (!r_ldone) begin
                        if (m2[31]) begin
                            r_m  <= m2[31:1];
                            r_l2 <= r_l2 + (22'sd1 <<< (5'd15 - r_sqi));
                        end else begin
                            r_m <= m2[30:0];
                        end
                        r_sqi <= r_sqi + 1'b1;
                        if (r_sqi == 5'd15) r_ldone <= 1'b1;
                    end
                    if (r_cnt == '0 && r_ldone) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_u2    <= {26'b0, u} * {26'b0, u};
                    r_lnp   <= 56'(r_l2) * 56'($signed({1'b0, LN2_Q32}));
                    r_sub   <= 4'd1;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_sub != '0) begin
                        r_t   <= (tsum > 49'(TOT_MAX)) ? TOT_MAX :
                                 (tsum < 49'(TOT_MIN)) ? TOT_MIN : 48'(tsum);
                        r_sub <= '0;
                    end else if (!r_row.last || !r_out_valid) begin
                        r_prev_sample <= r_row.sample;
                        r_prev_fit    <= r_row.fit;
                        if (r_row.last) begin
                            r_out_total <= r_t;
                            r_out_valid <= 1'b1;
                            r_total     <= '0;
                            r_first     <= 1'b1;
                        end else begin
                            r_total <= r_t;
                            r_first <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> test/ar1_ll_checker.sv
// Checker for the AR(1) log-likelihood unit: mirrors config writes, predicts
// series totals for accepted rows and compares them with popped totals.
// Depends on ar1_pkg.
`timescale 1ns / 1ps
module ar1_ll_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_push,
    input  logic               i_full,
    input  logic signed [31:0] i_beta_0,
    input  logic signed [31:0] i_beta_1,
    input  logic signed [31:0] i_beta_2,
    input  logic signed [31:0] i_beta_3,
    input  logic signed [31:0] i_rho,
    input  logic signed [31:0] i_sigma,
    input  logic signed [31:0] i_sample,
    input  logic               i_row_valid,
    input  logic               i_last_row,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic signed [47:0] i_total,
    output int                 o_fail_count,
    output int                 o_totals_pending
);
    import ar1_pkg::*;

    localparam longint TOTAL_MAX = 64'sd140737488355327;
    localparam longint TOTAL_MIN = -64'sd140737488355328;
    localparam longint unsigned LN2_FRAC = 64'd2977044472;
    localparam longint HALF_LN_TWO_PI = 64'sd60224;
    localparam longint unsigned DEV_CAP = 64'd1 << 25;

    logic signed [47:0] totals_due[$];
    longint row_floor;
    int     betas_used;
    longint last_sample, last_fit, series_sum;
    bit     series_start;

    // magnitude rounding, ties away from zero
    function automatic longint round_away(longint v, int s);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint ln_fixed(longint unsigned x);
        int p;
        longint unsigned m;
        longint l2;
        p = 0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        m = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
        l2 = longint'(p - 16) * 65536;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m >>= 1;
                l2 += longint'(64'd1 << (15 - i));
            end
        end
        return round_away(l2 * longint'(LN2_FRAC), 32);
    endfunction

    task automatic absorb_row();
        longint fit, rho, sigma, smp, mean, sd, score, d, t;
        longint unsigned root, ad, dev;
        longint betas[4];
        int nb;
        bit ok;
        betas = '{i_beta_0, i_beta_1, i_beta_2, i_beta_3};
        nb = (betas_used > NUM_BETAS) ? NUM_BETAS : betas_used;
        fit = 0;
        for (int k = 0; k < nb; k++) fit += betas[k];
        rho = i_rho;
        sigma = i_sigma;
        smp = i_sample;
        ok = i_row_valid && sigma > 0;
        mean = fit;
        sd = sigma;
        if (ok && !series_start) begin
            if (rho <= -65536 || rho >= 65536) begin
                ok = 0;
            end else begin
                root = int_sqrt((64'd1 << 32) - longint'(rho * rho));
                sd = longint'((longint'(sigma) * root) >> 16);
                mean = fit + round_away(rho * (last_sample - last_fit), 16);
            end
        end
        if (ok && sd <= 0) ok = 0;
        score = row_floor;
        if (ok) begin
            d = smp - mean;
            ad = (d < 0) ? -d : d;
            dev = (ad << 16) / longint'(sd);
            if (dev > DEV_CAP) dev = DEV_CAP;
            score = -ln_fixed(sd) - HALF_LN_TWO_PI - longint'((dev * dev + (64'd1 << 16)) >> 17);
            if (score < row_floor) score = row_floor;
        end
        t = series_sum + score;
        if (t > TOTAL_MAX) t = TOTAL_MAX;
        if (t < TOTAL_MIN) t = TOTAL_MIN;
        last_sample = smp;
        last_fit = fit;
        if (i_last_row) begin
            totals_due.push_back(t[47:0]);
            series_sum = 0;
            series_start = 1;
        end else begin
            series_sum = t;
            series_start = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_floor = MIN_LL_RESET;
            betas_used = NUM_BETAS_RESET;
            last_sample = 0;
            last_fit = 0;
            series_sum = 0;
            series_start = 1;
            totals_due.delete();
            o_fail_count <= 0;
            o_totals_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_MIN_LL) row_floor = longint'(signed'(i_cfg_data));
                else betas_used = i_cfg_data[2:0];
            end
            if (i_push && !i_full) absorb_row();
            if (i_pop && !i_empty) begin
                if (totals_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: total %0d popped with none expected", $time, i_total);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    logic signed [47:0] want;
                    want = totals_due.pop_front();
                    if (want !== i_total) begin
                        if (o_fail_count < 10)
                            $display("%0t: total mismatch, expected %0d got %0d",
                                     $time, want, i_total);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_totals_pending <= totals_due.size();
        end
    end
endmodule

>>> test/ar1_gaussian_log_likelihood_sum_unit_tb.sv
// Testbench top for the AR(1) log-likelihood unit: drives rows, config
// writes and result pops with random stalls; checking is in ar1_ll_checker.
// Depends on ar1_pkg, ar1_ll_checker and the unit itself.
`timescale 1ns / 1ps
module ar1_gaussian_log_likelihood_sum_unit_tb;
    import ar1_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0, i_cfg_addr = CFG_MIN_LL;
    logic [31:0] i_cfg_data = 0;
    logic push = 0, pop = 0;
    logic full, empty;
    logic signed [31:0] beta_0 = 0, beta_1 = 0, beta_2 = 0, beta_3 = 0;
    logic signed [31:0] rho = 0, sigma = 0, sample = 0;
    logic row_valid = 0, last_row = 0;
    logic signed [47:0] total;
    int fail_count, totals_pending;
    bit stalls_on = 1, hold_results = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    ar1_gaussian_log_likelihood_sum_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_beta_0(beta_0), .i_beta_1(beta_1), .i_beta_2(beta_2), .i_beta_3(beta_3),
        .i_rho(rho), .i_sigma(sigma), .i_sample(sample),
        .i_row_valid(row_valid), .i_last_row(last_row),
        .empty(empty), .pop(pop), .o_total_log_likelihood(total)
    );

    ar1_ll_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_push(push), .i_full(full),
        .i_beta_0(beta_0), .i_beta_1(beta_1), .i_beta_2(beta_2), .i_beta_3(beta_3),
        .i_rho(rho), .i_sigma(sigma), .i_sample(sample),
        .i_row_valid(row_valid), .i_last_row(last_row),
        .i_empty(empty), .i_pop(pop), .i_total(total),
        .o_fail_count(fail_count), .o_totals_pending(totals_pending)
    );

    // watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("ar1_gaussian_log_likelihood_sum_unit_tb failed");
            $finish;
        end
    end

    // result side
    initial begin
        forever begin
            if (hold_results) begin
                pop <= 0;
                repeat (400) @(posedge i_clk);
                hold_results = 0;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                pop <= 0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                pop <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_row(logic signed [31:0] b0, b1, b2, b3, r, s, x,
                            logic v, logic l);
        if (stalls_on && $urandom_range(0, 9) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push <= 1;
        beta_0 <= b0; beta_1 <= b1; beta_2 <= b2; beta_3 <= b3;
        rho <= r; sigma <= s; sample <= x;
        row_valid <= v; last_row <= l;
        do @(posedge i_clk); while (full);
    endtask

    // wait until every total is out and the engine has drained trailing rows
    task automatic drain();
        push <= 0;
        @(posedge i_clk);
        while (totals_pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic addr, logic [31:0] data);
        i_cfg_we <= 1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic signed [31:0] pick_value(logic signed [31:0] centre, int spread);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return centre + $signed($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // one series with random content, mostly well-formed
    task automatic send_series(int rows);
        logic signed [31:0] b[4];
        logic signed [31:0] r, s, x, fitv;
        for (int i = 0; i < rows; i++) begin
            foreach (b[k]) b[k] = pick_value(0, 1 << 18);
            fitv = b[0] + b[1] + b[2] + b[3];
            r = ($urandom_range(0, 15) == 0) ? $urandom : pick_value(0, 65535);
            s = ($urandom_range(0, 15) == 0) ? $urandom
                : $signed($urandom_range(1, 1 << $urandom_range(4, 22)));
            x = pick_value(fitv, s > 0 ? s * 3 : 1 << 16);
            send_row(b[0], b[1], b[2], b[3], r, s, x,
                     $urandom_range(0, 9) != 0, i == rows - 1);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed rows at reset config
        send_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 0, 32'sh7fffffff, 32'sh80000000, 1, 1);
        send_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh7fffffff, 32'sh00010000, 32'sh7fffffff, 1, 1);
        send_row(0, 0, 0, 0, 0, 32'sh00010000, 0, 1, 0);
        send_row(0, 0, 0, 0, 32'sh00010000, 32'sh00010000, 0, 1, 0);
        send_row(0, 0, 0, 0, -32'sh00010000, 32'sh00010000, 0, 1, 0);
        send_row(0, 0, 0, 0, 32'sh0000ffff, 32'sh00010000, 0, 1, 0);
        send_row(0, 0, 0, 0, -32'sh0000ffff, 32'sh00010000, 0, 1, 0);
        send_row(0, 0, 0, 0, 32'sh00008000, 0, 0, 1, 0);
        send_row(0, 0, 0, 0, 32'sh00008000, 32'sh80000000, 0, 1, 0);
        send_row(0, 0, 0, 0, 32'sh0000ff00, 1, 0, 1, 0);
        send_row(32'sh00010000, 0, 0, 0, 0, 32'sh00010000, 32'sh00400000, 0, 0);
        send_row(0, 32'sh00020000, 0, 0, 32'sh00004000, 32'sh00010000, 32'sh7fffffff, 1, 1);
        drain();

        write_cfg(CFG_MIN_LL, 32'h80000000);
        write_cfg(CFG_NUM_BETAS, 0);
        send_row(32'sh00050000, 32'sh1, 32'sh2, 32'sh3, 0, 32'sh00001000, 32'sh10000000, 1, 0);
        send_row(32'sh5, 32'sh1, 32'sh2, 32'sh3, 32'sh00002000, 32'sh00000010, 32'sh1000, 1, 0);
        send_row(32'sh5, 32'sh1, 32'sh2, 32'sh3, 32'sh00002000, 32'sh00000010, 0, 0, 1);
        drain();

        write_cfg(CFG_MIN_LL, 0);
        write_cfg(CFG_NUM_BETAS, 7);
        send_row(32'sh100, 32'sh200, 32'sh300, 32'sh400, 0, 32'sh00000100, 32'sh1000, 1, 0);
        send_row(32'sh100, 32'sh200, 32'sh300, 32'sh400, 0, 32'sh00000100, 32'sha00, 1, 1);
        drain();

        // random phases over several settings
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_cfg(CFG_MIN_LL, MIN_LL_RESET);
                         write_cfg(CFG_NUM_BETAS, NUM_BETAS_RESET); end
                1: begin write_cfg(CFG_MIN_LL, 32'h80000000);
                         write_cfg(CFG_NUM_BETAS, 1); end
                2: begin write_cfg(CFG_MIN_LL, 0); write_cfg(CFG_NUM_BETAS, 7); end
                default: begin
                    write_cfg(CFG_MIN_LL,
                              32'(-$signed({1'b0, $urandom_range(0, 32'h7fffffff)})));
                    write_cfg(CFG_NUM_BETAS, $urandom_range(0, 4));
                end
            endcase
            if (phase == 1) hold_results = 1;
            if (phase == 5) stalls_on = 0;
            for (int n = 0; n < 80; ) begin
                int rows;
                rows = $urandom_range(1, 8);
                send_series(rows);
                n += rows;
            end
            drain();
        end

        if (fail_count == 0 && totals_pending == 0)
            $display("ar1_gaussian_log_likelihood_sum_unit_tb passed");
        else
            $display("ar1_gaussian_log_likelihood_sum_unit_tb failed");
        $finish;
    end
endmodule
